>>> hw/rtl/ors_pkg.sv
// Shared types and constants for the 1-Wire ROM search engine.
package ors_pkg;

   // Fixed field widths of the search state.
   localparam int IdWidth      = 64;
   localparam int PosWidth     = 7;
   localparam int FamWidth     = 4;
   localparam int CrcWidth     = 8;
   localparam int IdxWidth     = 6;

   // Default ID length in bytes.
   localparam int ID_BYTES_DEFAULT = 8;

   // Reflected CRC8 polynomial and family byte limit.
   localparam logic [CrcWidth-1:0] CRC_POLY     = 8'h8C;
   localparam logic [PosWidth-1:0] FAMILY_LIMIT = 7'd9;

   // Request kinds carried on the request tuser.
   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BIT   = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // Result kinds carried on the response tuser.
   typedef enum logic [1:0] {
      ACT_NONE  = 2'd0,
      ACT_SEND  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_DONE  = 2'd3
   } action_type;

   // One request beat after unpacking.
   typedef struct packed {
      logic [1:0] op;
      logic       presence;
      logic       verify;
      logic       id_bit;
      logic       comp_bit;
   } req_beat_type;

   // One response beat before packing.
   typedef struct packed {
      action_type            action;
      logic                  direction_bit;
      logic                  found;
      logic [IdWidth-1:0]    rom_id;
      logic                  last_device;
      logic [FamWidth-1:0]   family_discrepancy;
   } rsp_beat_type;

endpackage

>>> hw/rtl/ors_input_reg.sv
// Input register that holds one request beat until the core takes it.
module ors_input_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  ors_pkg::req_beat_type in_beat,
   output logic                  out_valid,
   input  logic                  out_take,
   output ors_pkg::req_beat_type out_beat
);

   logic                  valid_ff;
   logic                  valid_in;
   ors_pkg::req_beat_type beat_ff;

   // A new beat may enter when the register is empty or drains this cycle.
   assign in_ready  = !valid_ff || out_take;
   assign valid_in  = (in_valid && in_ready) || (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   // Valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is loaded on every accepted beat.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         beat_ff <= in_beat;
      end
   end

endmodule

>>> hw/rtl/ors_core.sv
// Search state, one-step update logic and the result register.
module ors_core #(
   parameter int ID_BYTES = ors_pkg::ID_BYTES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_take,
   input  ors_pkg::req_beat_type in_beat,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ors_pkg::rsp_beat_type out_beat
);

   localparam int TotalBits = ID_BYTES * 8;
   localparam logic [ors_pkg::PosWidth-1:0] LastPos = ors_pkg::PosWidth'(TotalBits);
   localparam logic [ors_pkg::IdWidth-1:0]  IdMask  =
      {ors_pkg::IdWidth{1'b1}} >> (ors_pkg::IdWidth - TotalBits);

   // Search state registers and their next values.
   logic [ors_pkg::IdWidth-1:0]  id_ff, id_in;
   logic [ors_pkg::PosWidth-1:0] ld_ff, ld_in;
   logic [ors_pkg::FamWidth-1:0] fd_ff, fd_in;
   logic                         ldf_ff, ldf_in;
   logic                         searching_ff, searching_in;
   logic                         verifying_ff, verifying_in;
   logic [ors_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic [ors_pkg::PosWidth-1:0] lzp_ff, lzp_in;
   logic [ors_pkg::CrcWidth-1:0] crc_ff, crc_in;
   logic [ors_pkg::IdWidth-1:0]  sid_ff, sid_in;
   logic [ors_pkg::PosWidth-1:0] sld_ff, sld_in;
   logic [ors_pkg::FamWidth-1:0] sfd_ff, sfd_in;
   logic                         sldf_ff, sldf_in;

   // Result register.
   logic                  rsp_valid_ff;
   ors_pkg::rsp_beat_type rsp_ff, rsp_in;

   // The core moves a beat when the result register is free or draining.
   assign in_take   = in_valid && (!rsp_valid_ff || out_ready);
   assign out_valid = rsp_valid_ff;
   assign out_beat  = rsp_ff;

   // One search step for the beat in the input register.
   always_comb begin
      logic                         do_finish;
      logic                         fin_ok;
      logic                         dir;
      logic [ors_pkg::IdxWidth-1:0] idx;
      logic [ors_pkg::PosWidth-1:0] pos_next;
      ors_pkg::action_type          act;

      id_in        = id_ff;
      ld_in        = ld_ff;
      fd_in        = fd_ff;
      ldf_in       = ldf_ff;
      searching_in = searching_ff;
      verifying_in = verifying_ff;
      pos_in       = pos_ff;
      lzp_in       = lzp_ff;
      crc_in       = crc_ff;
      sid_in       = sid_ff;
      sld_in       = sld_ff;
      sfd_in       = sfd_ff;
      sldf_in      = sldf_ff;
      do_finish    = 1'b0;
      fin_ok       = 1'b0;
      dir          = 1'b0;
      idx          = pos_ff[ors_pkg::IdxWidth-1:0] - ors_pkg::IdxWidth'(1);
      pos_next     = pos_ff + ors_pkg::PosWidth'(1);
      act          = ors_pkg::ACT_NONE;

      unique case (in_beat.op)
         ors_pkg::OP_START: begin
            // Abandon any running pass, restoring a verify's saved state.
            if (verifying_ff) begin
               id_in  = sid_ff;
               ld_in  = sld_ff;
               fd_in  = sfd_ff;
               ldf_in = sldf_ff;
            end
            searching_in = 1'b0;
            verifying_in = 1'b0;
            if (in_beat.verify) begin
               sid_in       = id_in;
               sld_in       = ld_in;
               sfd_in       = fd_in;
               sldf_in      = ldf_in;
               ld_in        = LastPos;
               ldf_in       = 1'b0;
               verifying_in = 1'b1;
            end
            if (ldf_in || !in_beat.presence) begin
               do_finish = 1'b1;
            end else begin
               searching_in = 1'b1;
               pos_in       = ors_pkg::PosWidth'(1);
               lzp_in       = '0;
               crc_in       = '0;
               act          = ors_pkg::ACT_SEND;
            end
         end
         ors_pkg::OP_CLEAR: begin
            ld_in        = '0;
            fd_in        = '0;
            ldf_in       = 1'b0;
            searching_in = 1'b0;
            verifying_in = 1'b0;
         end
         ors_pkg::OP_BIT: begin
            if (searching_ff) begin
               if (in_beat.id_bit && in_beat.comp_bit) begin
                  // No device answered this bit: abort.
                  do_finish = 1'b1;
               end else begin
                  // Pick the direction, following the last discrepancy.
                  if (in_beat.id_bit != in_beat.comp_bit) begin
                     dir = in_beat.id_bit;
                  end else begin
                     if (pos_ff < ld_ff) begin
                        dir = id_ff[idx];
                     end else begin
                        dir = (pos_ff == ld_ff);
                     end
                     if (!dir) begin
                        lzp_in = pos_ff;
                        if (pos_ff < ors_pkg::FAMILY_LIMIT) begin
                           fd_in = pos_ff[ors_pkg::FamWidth-1:0];
                        end
                     end
                  end
                  id_in[idx] = dir;
                  pos_in     = pos_next;
                  // Bitwise CRC8, LSB first; matches the bytewise form at byte ends.
                  crc_in = (crc_ff >> 1) ^
                           ((crc_ff[0] ^ dir) ? ors_pkg::CRC_POLY : '0);
                  if (pos_next > LastPos) begin
                     fin_ok    = (crc_in == '0);
                     do_finish = 1'b1;
                     if (fin_ok) begin
                        ld_in = lzp_in;
                        if (lzp_in == '0) begin
                           ldf_in = 1'b1;
                        end
                     end
                  end else begin
                     act = ors_pkg::ACT_WRITE;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      // Common end of a search pass.
      if (do_finish) begin
         act = ors_pkg::ACT_DONE;
         if (!fin_ok || (id_in[7:0] == 8'd0)) begin
            ld_in  = '0;
            fd_in  = '0;
            ldf_in = 1'b0;
            fin_ok = 1'b0;
         end
         searching_in = 1'b0;
         if (verifying_in) begin
            fin_ok       = fin_ok && (((id_in ^ sid_in) & IdMask) == '0);
            id_in        = sid_in;
            ld_in        = sld_in;
            fd_in        = sfd_in;
            ldf_in       = sldf_in;
            verifying_in = 1'b0;
         end
      end

      rsp_in.action             = act;
      rsp_in.direction_bit      = dir;
      rsp_in.found              = fin_ok;
      rsp_in.rom_id             = id_in;
      rsp_in.last_device        = ldf_in;
      rsp_in.family_discrepancy = fd_in;
   end

   // State registers update on each taken beat.
   always_ff @(posedge clock) begin
      if (reset) begin
         id_ff        <= '0;
         ld_ff        <= '0;
         fd_ff        <= '0;
         ldf_ff       <= 1'b0;
         searching_ff <= 1'b0;
         verifying_ff <= 1'b0;
         pos_ff       <= ors_pkg::PosWidth'(1);
         lzp_ff       <= '0;
         crc_ff       <= '0;
         sid_ff       <= '0;
         sld_ff       <= '0;
         sfd_ff       <= '0;
         sldf_ff      <= 1'b0;
      end else if (in_take) begin
         id_ff        <= id_in;
         ld_ff        <= ld_in;
         fd_ff        <= fd_in;
         ldf_ff       <= ldf_in;
         searching_ff <= searching_in;
         verifying_ff <= verifying_in;
         pos_ff       <= pos_in;
         lzp_ff       <= lzp_in;
         crc_ff       <= crc_in;
         sid_ff       <= sid_in;
         sld_ff       <= sld_in;
         sfd_ff       <= sfd_in;
         sldf_ff      <= sldf_in;
      end
   end

   // Result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (in_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (in_take) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> hw/rtl/onewire_rom_search_engine.sv
// 1-Wire ROM search engine: one search step per request beat, one response per request.
// A request beat is held in the input register and stepped into the result register once
// that register is free or draining; its response is then held there until taken.
// Throughput: one request beat per cycle unless rsp_tready stalls the result register.
// Reset (synchronous, active high) empties both registers and returns the search
// state to its initial values: ID zero, no discrepancy, not searching.
module onewire_rom_search_engine #(
   parameter int ID_BYTES = ors_pkg::ID_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // presence, verify, id_bit, comp_bit, zero fill
   input  logic [1:0]  req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // direction_bit, found, rom_id[63:0], last_device,
                                    // family_discrepancy[3:0], zero fill
   output logic [1:0]  rsp_tuser    // action
);

   ors_pkg::req_beat_type req_beat;
   ors_pkg::req_beat_type core_beat;
   ors_pkg::rsp_beat_type rsp_beat;
   logic                  core_valid;
   logic                  core_take;

   // Unpack the request beat.
   assign req_beat.op         = req_tuser;
   assign req_beat.presence   = req_tdata[0];
   assign req_beat.verify     = req_tdata[1];
   assign req_beat.id_bit     = req_tdata[2];
   assign req_beat.comp_bit   = req_tdata[3];

   ors_input_reg u_input_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_beat   (req_beat),
      .out_valid (core_valid),
      .out_take  (core_take),
      .out_beat  (core_beat)
   );

   ors_core #(
      .ID_BYTES (ID_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_valid),
      .in_take   (core_take),
      .in_beat   (core_beat),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (rsp_beat)
   );

   // Pack the response beat.
   assign rsp_tuser        = rsp_beat.action;
   assign rsp_tdata[0]     = rsp_beat.direction_bit;
   assign rsp_tdata[1]     = rsp_beat.found;
   assign rsp_tdata[65:2]  = rsp_beat.rom_id;
   assign rsp_tdata[66]    = rsp_beat.last_device;
   assign rsp_tdata[70:67] = rsp_beat.family_discrepancy;
   assign rsp_tdata[71]    = 1'b0;

endmodule
